/* rtl/ita_pkg.sv */
// Shared types, constants and the digit-to-character map of the integer formatter.
`default_nettype none
package ita_pkg;

	localparam int BinW      = 64;
	localparam int DigitW    = 4;
	localparam int DecDigits = 20;
	localparam int HexDigits = 16;
	localparam int BcdW      = DecDigits * DigitW;
	localparam int CountW    = 5;
	localparam int WidthW    = 6;
	localparam int CharW     = 8;

	localparam logic [1:0] RadixDec   = 2'd0;
	localparam logic [1:0] RadixLower = 2'd1;

	localparam logic [CharW-1:0] CharMinus = 8'h2D;
	localparam logic [CharW-1:0] CharSpace = 8'h20;
	localparam logic [CharW-1:0] CharZero  = 8'h30;
	localparam logic [CharW-1:0] CharUpperA = 8'h41;
	localparam logic [CharW-1:0] CharLowerA = 8'h61;

	// per-number settings handed from the front end to the character sequencer
	typedef struct packed {
		logic              neg;
		logic              upper;
		logic              pad_zero;
		logic [WidthW-1:0] width;
	} ita_job_t;

	function automatic logic [CharW-1:0] ita_digit_char(input logic [DigitW-1:0] d,
		input logic upper);
		logic [CharW-1:0] dx;
		dx = {4'b0000, d};
		if (d < 4'd10) begin
			return CharZero + dx;
		end else if (upper) begin
			return CharUpperA + dx - 8'd10;
		end else begin
			return CharLowerA + dx - 8'd10;
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/ita_dabble.sv */
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
`default_nettype none
module ita_dabble
	import ita_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [BinW-1:0] bin,
	output logic                 done,
	output logic [BcdW-1:0]      bcd
);

	localparam int CntW = $clog2(BinW + 1);

	logic [BinW-1:0] bin_q;
	logic [BcdW-1:0] bcd_q;
	logic [CntW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [BcdW-1:0] adj;

	// each BCD digit gets +3 when it is five or more, before the shift
	for (genvar g = 0; g < DecDigits; g++) begin : g_adj
		always_comb begin
			if (bcd_q[g*DigitW +: DigitW] >= 4'd5) begin
				adj[g*DigitW +: DigitW] = bcd_q[g*DigitW +: DigitW] + 4'd3;
			end else begin
				adj[g*DigitW +: DigitW] = bcd_q[g*DigitW +: DigitW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(BinW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (run_q) begin
			bin_q <= {bin_q[BinW-2:0], 1'b0};
			bcd_q <= {adj[BcdW-2:0], bin_q[BinW-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
`default_nettype wire

/* rtl/ita_emit.sv */
// Character sequencer: leading-zero scan, then sign, pad and digits one per word.
`default_nettype none
module ita_emit
	import ita_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire ita_job_t          job,
	input  wire logic [BcdW-1:0]   digits,
	input  wire logic [CountW-1:0] ndig,
	output logic                   busy,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [CharW-1:0]       m_tdata,
	output logic                   m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SIGN,
		ST_PAD,
		ST_DIGIT
	} state_t;

	state_t             state_q;
	ita_job_t           job_q;
	logic [BcdW-1:0]    dig_q;
	logic [CountW-1:0]  ndig_q;
	logic [WidthW-1:0]  pad_q;
	logic               valid_q;
	logic [CharW-1:0]   char_q;
	logic               last_q;
	logic               adv;
	logic               out_state;
	logic [DigitW-1:0]  top_dig;
	logic [WidthW-1:0]  ndig_ext;
	logic [WidthW-1:0]  pad_calc;

	assign adv       = !valid_q || m_tready;
	assign out_state = (state_q == ST_SIGN) || (state_q == ST_PAD) || (state_q == ST_DIGIT);
	assign top_dig   = dig_q[BcdW-1 -: DigitW];
	assign ndig_ext  = {1'b0, ndig_q};
	assign pad_calc  = (job_q.width > ndig_ext) ? (job_q.width - ndig_ext) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			job_q   <= '0;
			dig_q   <= '0;
			ndig_q  <= '0;
			pad_q   <= '0;
			char_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			// a new word is loaded whenever the output register frees up in an output state
			if (adv) begin
				valid_q <= out_state;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						job_q   <= job;
						dig_q   <= digits;
						ndig_q  <= ndig;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (top_dig == '0 && ndig_q != CountW'(1)) begin
						dig_q  <= {dig_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
						ndig_q <= ndig_q - 1'b1;
					end else begin
						pad_q <= pad_calc;
						if (job_q.neg) begin
							state_q <= ST_SIGN;
						end else if (pad_calc != '0) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_DIGIT;
						end
					end
				end
				ST_SIGN: begin
					if (adv) begin
						char_q  <= CharMinus;
						last_q  <= 1'b0;
						state_q <= (pad_q != '0) ? ST_PAD : ST_DIGIT;
					end
				end
				ST_PAD: begin
					if (adv) begin
						char_q  <= job_q.pad_zero ? CharZero : CharSpace;
						last_q  <= 1'b0;
						pad_q   <= pad_q - 1'b1;
						if (pad_q == WidthW'(1)) begin
							state_q <= ST_DIGIT;
						end
					end
				end
				ST_DIGIT: begin
					if (adv) begin
						char_q  <= ita_digit_char(top_dig, job_q.upper);
						last_q  <= (ndig_q == CountW'(1));
						dig_q   <= {dig_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
						ndig_q  <= ndig_q - 1'b1;
						if (ndig_q == CountW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign m_tvalid = valid_q;
	assign m_tdata  = char_q;
	assign m_tlast  = last_q;

endmodule
`default_nettype wire

/* rtl/integer_to_ascii_formatter.sv */
// Top level: formats a 64-bit magnitude as padded decimal or hex ASCII, one char per word.
//
//  channel  | dir | handshake                      | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | s_axis_tdata (number and format)
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | m_axis_tdata (char), m_axis_tlast
//
// Decimal: serial BCD conversion after the accepting edge, a hand-off through TS_LAUNCH,
// then a leading-zero scan over the 20 BCD digits before the first word.
// Hex skips conversion: hand-off, then a scan over the 16 hex digits before the first word.
// Then one character per cycle while m_axis does not stall. The next number is taken once
// the current one is launched, so its conversion overlaps the output of the current one.
// arst_n clears all control state; no clearing pass is needed.
// Stalls on m_axis hold the output register and the sequencer; input waits as needed.
`default_nettype none
module integer_to_ascii_formatter
	import ita_pkg::*;
#(
	parameter int MAX_WIDTH = 63
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [63:0] magnitude, [64] negative, [66:65] radix_mode, [67] pad_zero,
	// [73:68] min_width, [79:74] zero
	input  wire logic [79:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] out_char
	output logic [7:0]       m_axis_tdata,
	output logic             m_axis_tlast
);

	localparam logic [WidthW-1:0] MaxW = WidthW'(MAX_WIDTH);

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_CONV,
		TS_LAUNCH
	} tstate_t;

	tstate_t           tstate_q;
	logic [BinW-1:0]   mag_q;
	logic              hex_q;
	ita_job_t          job_q;
	logic              in_acc;
	logic              conv_start;
	logic              conv_done;
	logic [BcdW-1:0]   bcd;
	logic              emit_start;
	logic              emit_busy;
	logic [BcdW-1:0]   emit_digits;
	logic [CountW-1:0] emit_ndig;
	logic [WidthW-1:0] in_width;
	logic [1:0]        in_radix;

	assign in_acc     = s_axis_tvalid && s_axis_tready;
	assign in_radix   = s_axis_tdata[66:65];
	assign in_width   = s_axis_tdata[73:68];
	assign conv_start = in_acc && (in_radix == RadixDec);
	assign emit_start = (tstate_q == TS_LAUNCH) && !emit_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tstate_q <= TS_IDLE;
			mag_q    <= '0;
			hex_q    <= 1'b0;
			job_q    <= '0;
		end else begin
			unique case (tstate_q)
				TS_IDLE: begin
					if (in_acc) begin
						mag_q          <= s_axis_tdata[63:0];
						hex_q          <= (in_radix != RadixDec);
						job_q.neg      <= s_axis_tdata[64];
						job_q.upper    <= in_radix[1];
						job_q.pad_zero <= s_axis_tdata[67];
						job_q.width    <= (in_width > MaxW) ? MaxW : in_width;
						tstate_q       <= (in_radix == RadixDec) ? TS_CONV : TS_LAUNCH;
					end
				end
				TS_CONV: begin
					if (conv_done) begin
						tstate_q <= TS_LAUNCH;
					end
				end
				TS_LAUNCH: begin
					if (!emit_busy) begin
						tstate_q <= TS_IDLE;
					end
				end
				default: tstate_q <= TS_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (tstate_q == TS_IDLE);
	assign emit_digits   = hex_q ? {mag_q, {(BcdW-BinW){1'b0}}} : bcd;
	assign emit_ndig     = hex_q ? CountW'(HexDigits) : CountW'(DecDigits);

	ita_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.bin    (s_axis_tdata[63:0]),
		.done   (conv_done),
		.bcd    (bcd)
	);

	ita_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (emit_start),
		.job      (job_q),
		.digits   (emit_digits),
		.ndig     (emit_ndig),
		.busy     (emit_busy),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast)
	);

`ifndef ASSERT_OFF
	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		conv_done |-> (tstate_q == TS_CONV))
		else $error("converter finished outside conversion wait");

	a_launch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit_start |=> emit_busy)
		else $error("sequencer did not pick up a launched number");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("input taken again before number launched");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata == CharMinus || m_axis_tdata == CharSpace ||
			(m_axis_tdata >= CharZero && m_axis_tdata <= 8'h39) ||
			(m_axis_tdata >= CharUpperA && m_axis_tdata <= 8'h46) ||
			(m_axis_tdata >= CharLowerA && m_axis_tdata <= 8'h66)))
		else $error("unexpected output character");
`endif

endmodule
`default_nettype wire

/* verif/integer_to_ascii_formatter_test.sv */
// Self-checking bench for integer_to_ascii_formatter: predicted text versus streamed words.
module integer_to_ascii_formatter_test
	import ita_pkg::*;
();

	localparam int MaxWidth    = 63;
	localparam int RandomItems = 408;
	localparam int DrainCycles = 200;
	localparam int CycleLimit  = 5000000;

	localparam logic [1:0] RadixUpper = 2'd2;
	localparam logic [1:0] RadixSpare = 2'd3;

	// field order matches s_axis_tdata from the top bit down
	typedef struct packed {
		logic [5:0]  min_width;
		logic        pad_zero;
		logic [1:0]  radix_mode;
		logic        negative;
		logic [63:0] magnitude;
	} number_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} char_word_t;

	class format_board;
		char_word_t expected_chars[$];
		int errors;
		int numbers;
		int words;

		// works out the text of one accepted number and queues it
		function void note_number(number_t n);
			logic [7:0]  digits [DecDigits];
			logic [63:0] v;
			logic [3:0]  d;
			int count;
			int width;
			char_word_t text[$];
			char_word_t w;
			v = n.magnitude;
			count = 0;
			do begin
				if (n.radix_mode == RadixDec) begin
					d = 4'(v % 64'd10);
					v = v / 64'd10;
				end else begin
					d = v[3:0];
					v = v >> 4;
				end
				if (d < 4'd10)
					digits[count] = CharZero + {4'b0000, d};
				else if (n.radix_mode == RadixLower)
					digits[count] = CharLowerA + {4'b0000, d} - 8'd10;
				else
					digits[count] = CharUpperA + {4'b0000, d} - 8'd10;
				count++;
			end while (v != 0 && count < DecDigits);
			width = int'(n.min_width);
			if (width > MaxWidth)
				width = MaxWidth;
			w.last = 1'b0;
			if (n.negative) begin
				w.ch = CharMinus;
				text = {text, w};
			end
			for (int i = count; i < width; i++) begin
				w.ch = n.pad_zero ? CharZero : CharSpace;
				text = {text, w};
			end
			for (int i = count - 1; i >= 0; i--) begin
				w.ch = digits[i];
				text = {text, w};
			end
			text[text.size() - 1].last = 1'b1;
			expected_chars = {expected_chars, text};
			numbers++;
		endfunction

		function void check_char(logic [7:0] ch, logic lst);
			char_word_t want;
			words++;
			if (expected_chars.size() == 0) begin
				errors++;
				$display("%0t: word with nothing expected: char %h last %b", $time, ch, lst);
				return;
			end
			want = expected_chars.pop_front();
			if (ch !== want.ch) begin
				errors++;
				$display("%0t: char expected %h got %h", $time, want.ch, ch);
			end
			if (lst !== want.last) begin
				errors++;
				$display("%0t: last expected %b got %b", $time, want.last, lst);
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;

	format_board board = new();
	bit src_gaps = 1'b0;
	bit sink_stalls = 1'b0;
	int cycles = 0;

	integer_to_ascii_formatter #(
		.MAX_WIDTH(MaxWidth)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_span();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic number_t mk(logic [63:0] mag, logic neg, logic [1:0] radix,
		logic padz, logic [5:0] w);
		number_t n;
		n.magnitude  = mag;
		n.negative   = neg;
		n.radix_mode = radix;
		n.pad_zero   = padz;
		n.min_width  = w;
		return n;
	endfunction

	function automatic number_t random_number();
		number_t n;
		int unsigned pick;
		logic [63:0] p;
		pick = $urandom_range(0, 99);
		n.magnitude = {$urandom, $urandom};
		if (pick < 40) begin
			n.magnitude = n.magnitude >> $urandom_range(0, 63);
		end else if (pick < 55) begin
			n.magnitude = 64'($urandom_range(0, 20));
		end else if (pick < 70) begin
			// around a power of ten, where the decimal digit count steps
			p = 64'd1;
			repeat ($urandom_range(1, 19)) p = p * 64'd10;
			n.magnitude = p + 64'($urandom_range(0, 2)) - 64'd1;
		end else if (pick < 80) begin
			n.magnitude = {64{1'b1}} >> $urandom_range(0, 63);
		end
		n.negative   = 1'($urandom_range(0, 1));
		n.radix_mode = 2'($urandom_range(0, 3));
		n.pad_zero   = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 8)
			n.min_width = 6'($urandom_range(0, 24));
		else
			n.min_width = 6'($urandom_range(25, 63));
		return n;
	endfunction

	// valid stays high across back-to-back numbers; lowered only for a gap
	task automatic send_number(input number_t n);
		int gap;
		gap = src_gaps ? idle_span() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b000000, n};
		do @(posedge clk); while (!s_axis_tready);
		board.note_number(n);
	endtask

	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				board.check_char(m_axis_tdata, m_axis_tlast);
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (sink_stalls)
					hold = idle_span();
			end
		end
	end

	initial begin
		number_t directed[$];
		int n_directed;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = {directed, mk(64'd0, 1'b0, RadixDec, 1'b0, 6'd0)};
		directed = {directed, mk(64'd0, 1'b1, RadixDec, 1'b1, 6'd63)};
		directed = {directed, mk(64'd0, 1'b1, RadixUpper, 1'b0, 6'd63)};
		directed = {directed, mk({64{1'b1}}, 1'b0, RadixDec, 1'b0, 6'd0)};
		directed = {directed, mk({64{1'b1}}, 1'b1, RadixLower, 1'b0, 6'd0)};
		directed = {directed, mk({64{1'b1}}, 1'b0, RadixUpper, 1'b1, 6'd0)};
		// unused radix code prints as uppercase hex
		directed = {directed, mk({64{1'b1}}, 1'b0, RadixSpare, 1'b0, 6'd0)};
		directed = {directed, mk(64'hFEDC_BA98_7654_3210, 1'b1, RadixLower, 1'b1, 6'd20)};
		directed = {directed, mk(64'hFEDC_BA98_7654_3210, 1'b0, RadixSpare, 1'b0, 6'd17)};
		directed = {directed, mk(64'd10000000000000000000, 1'b0, RadixDec, 1'b0, 6'd25)};
		directed = {directed, mk(64'd9999999999999999999, 1'b1, RadixDec, 1'b1, 6'd19)};
		// width under the digit count: no padding, no truncation
		directed = {directed, mk(64'd12345, 1'b0, RadixDec, 1'b1, 6'd3)};
		directed = {directed, mk(64'hABCDEF, 1'b0, RadixLower, 1'b1, 6'd8)};
		directed = {directed, mk(64'd9, 1'b1, RadixDec, 1'b0, 6'd1)};
		directed = {directed, mk(64'd10, 1'b0, RadixDec, 1'b0, 6'd2)};
		directed = {directed, mk(64'd15, 1'b0, RadixUpper, 1'b0, 6'd63)};
		directed = {directed, mk(64'd16, 1'b1, RadixSpare, 1'b1, 6'd5)};
		directed = {directed, mk(64'd1, 1'b1, RadixLower, 1'b0, 6'd0)};
		directed = {directed, mk(64'h8000_0000_0000_0000, 1'b0, RadixDec, 1'b1, 6'd40)};
		directed = {directed, mk(64'd255, 1'b1, RadixDec, 1'b1, 6'd62)};
		directed = {directed, mk(64'h0123_4567_89AB_CDEF, 1'b0, RadixLower, 1'b0, 6'd42)};

		n_directed = directed.size();
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		foreach (directed[i])
			send_number(directed[i]);

		// four stretches: quiet, sender gaps, receiver stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			src_gaps = (phase & 1) != 0;
			sink_stalls = (phase & 2) != 0;
			repeat (RandomItems / 4) send_number(random_number());
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("formatted %0d numbers (%0d directed) in decimal, lower and upper hex",
			board.numbers, n_directed);
		$display("checked %0d chars over widths 0..63, %0d mismatches, %0d left waiting",
			board.words, board.errors, board.pending());
		if (board.errors == 0 && board.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
